[rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

	localparam logic [31:0] EMPTY_WORD = 32'h8000_0000;
	localparam int MAX_DUMP = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_DUMP       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_POP,
		FSM_DUMP
	} fsm_t;

	typedef struct packed {
		logic [31:0] item;
		logic        item_valid;
		logic        last;
		logic        is_empty;
		logic [5:0]  count;
		logic [31:0] rear;
		logic [31:0] front;
		status_t     status;
	} res_t;

	function automatic res_t make_res(input status_t st, input logic [5:0] cnt,
			input logic empty, input logic [31:0] fr, input logic [31:0] rr,
			input logic [31:0] item, input logic iv, input logic lst);
		res_t r;
		r.status     = st;
		r.count      = cnt;
		r.is_empty   = empty;
		r.front      = empty ? EMPTY_WORD : fr;
		r.rear       = empty ? EMPTY_WORD : rr;
		r.item       = iv ? item : 32'd0;
		r.item_valid = iv;
		r.last       = lst;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/double_ended_queue.sv]
// channel | direction | tdata                               | tuser                   | tlast
// s_*     | in        | [31:0] push_value                   | [2:0] op                | -
// m_*     | out       | front, rear, count, is_empty, item  | status, item_valid      | last
//
// Push, clear, no-op, a pop that empties the deque and a dump of an empty
// deque are answered from the idle state. A pop that leaves words behind
// goes through the pop state, as the ring memory has a registered read port.
// A dump of n words: one word per cycle after the first read, unless stalled.
// Reset clears head, count, state, read-pending and output valid; the ring memory is never cleared.
// While a result is valid and m_tready is low, the result holds and no new word is taken.
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [31:0]  s_tdata,  // [31:0] push_value
	input  wire logic [2:0]   s_tuser,  // [2:0] op
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [103:0] m_tdata,  // [31:0] front, [63:32] rear, [69:64] count,
	                                    // [70] is_empty, [102:71] item_value, [103] zero
	output      logic [2:0]   m_tuser,  // [1:0] status, [2] item_valid
	output      logic         m_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OW = (CW > 6) ? CW : 6;

	logic [31:0]   ring_q [DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [31:0]   front_q, front_d, rear_q, rear_d;
	deq_pkg::fsm_t state_q, state_d;
	logic          pop_front_q, pop_front_d;
	logic [5:0]    dump_n_q, dump_n_d, idx_rd_q, idx_rd_d, idx_out_q, idx_out_d;
	logic          rd_pend_q, rd_pend_d;
	logic          out_valid_q;
	deq_pkg::res_t out_q, out_d;
	logic          out_load, out_free, s_fire;
	logic          mem_we, rd_en;
	logic [AW-1:0] waddr, rd_addr, head_m1;
	logic          go_pop, go_dump, dump_done, pop_done;
	logic          q_empty, q_full;

	function automatic logic [AW-1:0] pos(input logic [AW-1:0] hd, input logic [OW-1:0] off);
		logic [OW:0] sum;
		sum = (OW+1)'(hd) + (OW+1)'(off);
		if (sum >= (OW+1)'(DEPTH))
			sum = sum - (OW+1)'(DEPTH);
		return sum[AW-1:0];
	endfunction

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == deq_pkg::FSM_IDLE) && out_free;
	assign s_fire   = s_tvalid && s_tready;
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CW'(DEPTH));
	assign head_m1  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

	always_comb begin
		head_d      = head_q;
		count_d     = count_q;
		front_d     = front_q;
		rear_d      = rear_q;
		pop_front_d = pop_front_q;
		dump_n_d    = dump_n_q;
		idx_rd_d    = idx_rd_q;
		idx_out_d   = idx_out_q;
		rd_pend_d   = rd_pend_q;
		mem_we      = 1'b0;
		waddr       = head_q;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		out_load    = 1'b0;
		go_pop      = 1'b0;
		go_dump     = 1'b0;
		dump_done   = 1'b0;
		pop_done    = 1'b0;
		out_d       = deq_pkg::make_res(deq_pkg::ST_DONE, 6'(count_q), q_empty,
			front_q, rear_q, 32'd0, 1'b0, 1'b1);
		unique case (state_q)
			deq_pkg::FSM_IDLE: begin
				if (s_fire) begin
					out_load = 1'b1;
					unique case (s_tuser)
						deq_pkg::OP_PUSH_FRONT: begin
							if (q_full) begin
								out_d.status = deq_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								waddr   = head_m1;
								head_d  = head_m1;
								count_d = count_q + CW'(1);
								front_d = s_tdata;
								rear_d  = q_empty ? s_tdata : rear_q;
								out_d   = deq_pkg::make_res(deq_pkg::ST_DONE, 6'(count_d),
									1'b0, front_d, rear_d, 32'd0, 1'b0, 1'b1);
							end
						end
						deq_pkg::OP_PUSH_REAR: begin
							if (q_full) begin
								out_d.status = deq_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								waddr   = pos(head_q, OW'(count_q));
								count_d = count_q + CW'(1);
								rear_d  = s_tdata;
								front_d = q_empty ? s_tdata : front_q;
								out_d   = deq_pkg::make_res(deq_pkg::ST_DONE, 6'(count_d),
									1'b0, front_d, rear_d, 32'd0, 1'b0, 1'b1);
							end
						end
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
							if (q_empty) begin
								out_d.status = deq_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
								if (s_tuser == deq_pkg::OP_POP_FRONT)
									head_d = pos(head_q, OW'(1));
								if (count_q == CW'(1)) begin
									out_d = deq_pkg::make_res(deq_pkg::ST_DONE, 6'd0, 1'b1,
										front_q, rear_q, 32'd0, 1'b0, 1'b1);
								end else begin
									out_load    = 1'b0;
									go_pop      = 1'b1;
									rd_en       = 1'b1;
									pop_front_d = (s_tuser == deq_pkg::OP_POP_FRONT);
									rd_addr     = pop_front_d ? pos(head_q, OW'(1))
										: pos(head_q, OW'(count_q - CW'(2)));
								end
							end
						end
						deq_pkg::OP_CLEAR: begin
							head_d  = '0;
							count_d = '0;
							out_d   = deq_pkg::make_res(deq_pkg::ST_DONE, 6'd0, 1'b1,
								front_q, rear_q, 32'd0, 1'b0, 1'b1);
						end
						deq_pkg::OP_DUMP: begin
							if (!q_empty) begin
								out_load  = 1'b0;
								go_dump   = 1'b1;
								dump_n_d  = (32'(count_q) > deq_pkg::MAX_DUMP)
									? 6'(deq_pkg::MAX_DUMP) : 6'(count_q);
								idx_rd_d  = '0;
								idx_out_d = '0;
								rd_pend_d = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			deq_pkg::FSM_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					pop_done = 1'b1;
					if (pop_front_q)
						front_d = rdata_q;
					else
						rear_d = rdata_q;
					out_d = deq_pkg::make_res(deq_pkg::ST_DONE, 6'(count_q), 1'b0,
						front_d, rear_d, 32'd0, 1'b0, 1'b1);
				end
			end
			deq_pkg::FSM_DUMP: begin
				out_load = rd_pend_q && out_free;
				rd_en    = (idx_rd_q < dump_n_q) && (!rd_pend_q || out_load);
				rd_addr  = pos(head_q, OW'(idx_rd_q));
				if (rd_en)
					idx_rd_d = idx_rd_q + 6'd1;
				if (out_load) begin
					idx_out_d = idx_out_q + 6'd1;
					dump_done = (idx_out_q == dump_n_q - 6'd1);
				end
				rd_pend_d = rd_en || (rd_pend_q && !out_load);
				out_d = deq_pkg::make_res(deq_pkg::ST_DONE, 6'(count_q), 1'b0,
					front_q, rear_q, rdata_q, 1'b1, dump_done);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::FSM_IDLE: begin
				if (go_pop)
					state_d = deq_pkg::FSM_POP;
				else if (go_dump)
					state_d = deq_pkg::FSM_DUMP;
			end
			deq_pkg::FSM_POP: begin
				if (pop_done)
					state_d = deq_pkg::FSM_IDLE;
			end
			deq_pkg::FSM_DUMP: begin
				if (dump_done)
					state_d = deq_pkg::FSM_IDLE;
			end
			default: state_d = deq_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ring_q[waddr] <= s_tdata;
		if (rd_en)
			rdata_q <= ring_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::FSM_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			rd_pend_q <= rd_pend_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		front_q     <= front_d;
		rear_q      <= rear_d;
		pop_front_q <= pop_front_d;
		dump_n_q    <= dump_n_d;
		idx_rd_q    <= idx_rd_d;
		idx_out_q   <= idx_out_d;
		if (out_load)
			out_q <= out_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.item, out_q.is_empty, out_q.count, out_q.rear, out_q.front};
	assign m_tuser  = {out_q.item_valid, out_q.status};
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

[rtl/deq_checker.sv]
`default_nettype none

module deq_checker #(
	parameter int DEPTH = 32
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [31:0]  s_tdata,
	input wire logic [2:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata,
	input wire logic [2:0]   m_tuser,
	input wire logic         m_tlast
);

	logic unused_in;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == deq_pkg::ST_FULL |-> m_tdata[69:64] == 6'(DEPTH))
		else $error("push dropped while not full");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[70] |-> m_tdata[31:0] == deq_pkg::EMPTY_WORD
			&& m_tdata[63:32] == deq_pkg::EMPTY_WORD && m_tdata[69:64] == 6'd0)
		else $error("empty deque shows stored words");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == deq_pkg::ST_EMPTY |-> m_tdata[70] && !m_tuser[2])
		else $error("pop ignored on a non-empty deque");

	a_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata[102:71] == 32'd0)
		else $error("non-dump result not final or carries an item");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
module tb_top;

	localparam int DEPTH = 32;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] value;
	} deq_cmd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	deq_cmd_t        cmd_queue[$];
	deq_pkg::res_t   expected_results[$];
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              fail_count = 0;
	logic            word_taken = 1'b0;
	logic            hold_go = 1'b0;
	logic            hold_off = 1'b0;

	logic [31:0] ring[DEPTH];
	logic [4:0]  head_pos = '0;
	logic [5:0]  fill = '0;

	function automatic deq_pkg::res_t snapshot(input deq_pkg::status_t st,
			input logic [31:0] item, input logic iv, input logic lst);
		deq_pkg::res_t r;
		logic [4:0]    rear_pos;
		rear_pos     = head_pos + 5'(fill - 6'd1);
		r.status     = st;
		r.is_empty   = (fill == 0);
		r.count      = fill;
		r.front      = (fill == 0) ? deq_pkg::EMPTY_WORD : ring[head_pos];
		r.rear       = (fill == 0) ? deq_pkg::EMPTY_WORD : ring[rear_pos];
		r.item       = iv ? item : 32'd0;
		r.item_valid = iv;
		r.last       = lst;
		return r;
	endfunction

	task automatic apply_command(input logic [2:0] op, input logic [31:0] word);
		deq_pkg::status_t st;
		logic [4:0]       pos;
		st = deq_pkg::ST_DONE;
		case (op)
			deq_pkg::OP_PUSH_FRONT: begin
				if (fill == DEPTH) begin
					st = deq_pkg::ST_FULL;
				end else begin
					head_pos = head_pos - 5'd1;
					ring[head_pos] = word;
					fill = fill + 6'd1;
				end
			end
			deq_pkg::OP_PUSH_REAR: begin
				if (fill == DEPTH) begin
					st = deq_pkg::ST_FULL;
				end else begin
					pos = head_pos + fill[4:0];
					ring[pos] = word;
					fill = fill + 6'd1;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				if (fill == 0) begin
					st = deq_pkg::ST_EMPTY;
				end else begin
					head_pos = head_pos + 5'd1;
					fill = fill - 6'd1;
				end
			end
			deq_pkg::OP_POP_REAR: begin
				if (fill == 0) st = deq_pkg::ST_EMPTY;
				else fill = fill - 6'd1;
			end
			deq_pkg::OP_CLEAR: begin
				head_pos = '0;
				fill = '0;
			end
			deq_pkg::OP_DUMP: begin
				if (fill != 0) begin
					for (int i = 0; i < fill && i < deq_pkg::MAX_DUMP; i++) begin
						pos = head_pos + 5'(i);
						expected_results.push_back(snapshot(deq_pkg::ST_DONE, ring[pos],
								1'b1, (i == fill - 1) || (i == deq_pkg::MAX_DUMP - 1)));
					end
					return;
				end
			end
			default: ;
		endcase
		expected_results.push_back(snapshot(st, 32'd0, 1'b0, 1'b1));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic compare_result(input deq_pkg::res_t want);
		check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
		check_field("front", want.front, m_tdata[31:0]);
		check_field("rear", want.rear, m_tdata[63:32]);
		check_field("count", 32'(want.count), 32'(m_tdata[69:64]));
		check_field("is_empty", 32'(want.is_empty), 32'(m_tdata[70]));
		check_field("item_value", want.item, m_tdata[102:71]);
		check_field("item_valid", 32'(want.item_valid), 32'(m_tuser[2]));
		check_field("last", 32'(want.last), 32'(m_tlast));
	endtask

	// monitor: predict on accepted input words, check accepted output words
	always @(posedge clk) begin
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			word_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: tdata %h tuser %h tlast %b",
								m_tdata, m_tuser, m_tlast);
				end else begin
					compare_result(expected_results.pop_front());
				end
			end
		end
	end

	// driver: advance to the next word once the current one is taken
	always @(negedge clk) begin : drive
		deq_cmd_t cmd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd = cmd_queue.pop_front();
				s_tuser  <= cmd.op;
				s_tdata  <= cmd.value;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off
	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (300) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [31:0] random_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic add(input logic [2:0] op, input logic [31:0] value);
		deq_cmd_t c;
		c.op = op;
		c.value = value;
		cmd_queue.push_back(c);
	endtask

	task automatic add_push();
		add($urandom_range(1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT,
				random_word());
	endtask

	task automatic add_pop();
		add($urandom_range(1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT, $urandom);
	endtask

	task automatic add_random(input int n);
		int added;
		int k;
		int pick;
		added = 0;
		while (added < n) begin
			case ($urandom_range(5))
				0, 1: begin
					k = $urandom_range(34, 38);
					repeat (k) add_push();
					add(deq_pkg::OP_DUMP, $urandom);
					added += k + 1;
				end
				2: begin
					k = $urandom_range(30, 36);
					repeat (k) add_pop();
					add(deq_pkg::OP_DUMP, $urandom);
					added += k + 1;
				end
				3: begin
					add(deq_pkg::OP_CLEAR, $urandom);
					add(deq_pkg::OP_DUMP, $urandom);
					added += 2;
				end
				default: begin
					repeat (10) begin
						pick = $urandom_range(99);
						if (pick < 40) add_push();
						else if (pick < 75) add_pop();
						else if (pick < 85) add(deq_pkg::OP_DUMP, $urandom);
						else if (pick < 90) add(deq_pkg::OP_CLEAR, $urandom);
						else add(3'($urandom_range(6, 7)), $urandom);
					end
					added += 10;
				end
			endcase
		end
	endtask

	task automatic drain();
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add(deq_pkg::OP_DUMP, 32'h0);
		add(deq_pkg::OP_POP_FRONT, 32'h0);
		add(deq_pkg::OP_POP_REAR, 32'hffff_ffff);
		add(3'd6, 32'h1234_5678);
		add(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
		add(deq_pkg::OP_PUSH_REAR, 32'h8000_0000);
		add(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
		add(deq_pkg::OP_PUSH_REAR, 32'hffff_ffff);
		add(deq_pkg::OP_DUMP, 32'h0);
		add(deq_pkg::OP_POP_FRONT, 32'h0);
		add(deq_pkg::OP_DUMP, 32'h0);
		add(deq_pkg::OP_POP_REAR, 32'h0);
		add(3'd7, 32'hffff_ffff);
		add(deq_pkg::OP_PUSH_FRONT, $urandom);
		add(deq_pkg::OP_CLEAR, 32'h0);
		add(deq_pkg::OP_DUMP, 32'h0);
		add(deq_pkg::OP_POP_FRONT, 32'h0);
		add(deq_pkg::OP_PUSH_REAR, 32'h0000_0001);
		add(deq_pkg::OP_POP_FRONT, 32'h0);
		add(deq_pkg::OP_DUMP, 32'h0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			add_random(50);
			drain();
		end

		// fill the block while the receiver holds off
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		repeat (36) add_push();
		add(deq_pkg::OP_DUMP, 32'h0);
		repeat (10) add_pop();
		drain();

		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
